[rtl/pnu_pkg.sv]
package pnu_pkg;

	localparam int TAB_BITS  = 10;
	localparam int TAB_SIZE  = 1 << TAB_BITS;
	localparam int NSTG      = 14;
	localparam int CFG_IDX_W = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_AMOUNT = 8'd0,
		REG_GAUSS  = 8'd1,
		REG_MONO   = 8'd2,
		REG_SEED   = 8'd3
	} cfg_reg_t;

	localparam logic [31:0] MIX_C1   = 32'h7feb352d;
	localparam logic [31:0] MIX_C2   = 32'h846ca68b;
	localparam logic [31:0] KEY_SALT = 32'h68e31da4;
	localparam logic [31:0] KEY_OFS [3] = '{32'h00000000, 32'h9e3779b9, 32'h3c6ef372};

	// noise scale: amount * K / (60000 * 2^16), 765 for uniform, 510 for gaussian
	localparam logic [9:0]  AMT_K_GAUSS = 10'd510;
	localparam logic [9:0]  AMT_K_UNIF  = 10'd765;
	localparam logic [10:0] NZ_DIV      = 11'd1875;
	localparam logic [49:0] NZ_BIAS     = 50'd1966080000;
	localparam int          NZ_SH       = 21;
	localparam logic [28:0] NZ_RECIP    = 29'd293203100;
	localparam int          NZ_RSH      = 39;

	localparam logic [15:0] V_MAX = 16'd65535;
	localparam logic [15:0] S_MAX = 16'd65280;

	typedef logic [15:0] tab16_t [TAB_SIZE];
	typedef logic [24:0] rcp_t [256];

	function automatic logic [31:0] xs16(input logic [31:0] x);
		return x ^ (x >> 16);
	endfunction

	function automatic logic [31:0] xs15(input logic [31:0] x);
		return x ^ (x >> 15);
	endfunction

	// shift-and-subtract quotient for the table builders
	function automatic longint unsigned udiv(input longint unsigned num,
		input longint unsigned den);
		longint unsigned q, r;
		q = 0;
		r = 0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], num[b]};
			if (r >= den) begin
				r -= den;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// 2 * atanh(z), z in Q32
	function automatic longint unsigned log_ratio(input longint unsigned z);
		longint unsigned z2, pw, sum;
		z2 = (z * z) >> 32;
		pw = z;
		sum = z;
		for (longint unsigned k = 1; k <= 15; k++) begin
			pw = (pw * z2) >> 32;
			sum += udiv(pw, 2 * k + 1);
		end
		return 2 * sum;
	endfunction

	function automatic longint unsigned isqrt(input longint unsigned v_in);
		longint unsigned v, res, b;
		v = v_in;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// sqrt(-2 ln(1 - (i + 0.5) / N)) in Q4.12
	function automatic tab16_t build_rad();
		tab16_t t;
		longint unsigned n, d, ln2, m, k, y, lny, l, one32;
		one32 = 64'd1 << 32;
		n = TAB_SIZE;
		d = 2 * n;
		ln2 = log_ratio(64'h55555555);
		for (int i = 0; i < TAB_SIZE; i++) begin
			m = d - (2 * longint'(i) + 1);
			k = 0;
			while ((m >> (k + 1)) != 0) k++;
			y = (m << 32) >> k;
			lny = log_ratio(udiv((y - one32) << 32, y + one32));
			l = (longint'(TAB_BITS + 1) - k) * ln2;
			l = (l > lny) ? l - lny : 0;
			l *= 2;
			t[i] = 16'((isqrt(l) + 8) >> 4);
		end
		return t;
	endfunction

	// cos(2 pi (i + 0.5) / N) in signed Q3.12
	function automatic tab16_t build_cos();
		tab16_t t;
		longint unsigned n, d, tt, a, a2, term, one30, pi30;
		longint sum, c;
		logic neg;
		one30 = 64'd1 << 30;
		pi30 = 64'd3373259426;
		n = TAB_SIZE;
		d = 2 * n;
		for (int i = 0; i < TAB_SIZE; i++) begin
			tt = 2 * longint'(i) + 1;
			neg = 1'b0;
			if (tt > n) tt = d - tt;
			if (2 * tt > n) begin
				neg = 1'b1;
				tt = n - tt;
			end
			a = (pi30 * tt) >> TAB_BITS;
			a2 = (a * a) >> 30;
			term = one30;
			sum = longint'(one30);
			for (longint unsigned j = 1; j <= 12; j++) begin
				term = udiv((term * a2) >> 30, (2 * j - 1) * (2 * j));
				if (j[0]) sum -= longint'(term);
				else sum += longint'(term);
			end
			if (sum < 0) sum = 0;
			c = longint'((unsigned'(sum) + (64'd1 << 17)) >> 18);
			t[i] = neg ? 16'(-c) : 16'(c);
		end
		return t;
	endfunction

	// floor(2^24 / a), zero for a zero alpha
	function automatic rcp_t build_rcp();
		rcp_t r;
		for (int a = 0; a < 256; a++) begin
			r[a] = (a == 0) ? 25'd0 : 25'(udiv(64'd1 << 24, longint'(a)));
		end
		return r;
	endfunction

	localparam tab16_t RAD_TAB = build_rad();
	localparam tab16_t COS_TAB = build_cos();
	localparam rcp_t   RCP_TAB = build_rcp();

endpackage

[rtl/pnu_ifs.sv]
interface pnu_pix_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] pixel_index;
	logic [7:0]  red_in;
	logic [7:0]  green_in;
	logic [7:0]  blue_in;
	logic [7:0]  alpha_in;
	modport source (output valid, pixel_index, red_in, green_in, blue_in, alpha_in, input ready);
	modport sink (input valid, pixel_index, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface pnu_pix_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_out;
	logic [7:0] green_out;
	logic [7:0] blue_out;
	logic [7:0] alpha_out;
	modport source (output valid, red_out, green_out, blue_out, alpha_out, input ready);
	modport sink (input valid, red_out, green_out, blue_out, alpha_out, output ready);
endinterface

interface pnu_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [pnu_pkg::CFG_IDX_W-1:0] index;
	logic [31:0]                    data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/premultiplied_pixel_noise_unit.sv]
// pipeline: 14 register stages, stage 1 through stage 14, the output is driven from stage 14
// throughput: one pixel per cycle unless pix_out stalls, each stage a register after at most one multiplier
// stalls: each stage holds while the one after it is full and stalled, bubbles collapse
// reset: arst_n clears all stage valid bits and the four config registers to zero
// the radius, cosine and reciprocal lookups are constants, nothing to fill after reset
module premultiplied_pixel_noise_unit (
	input logic clk,
	input logic arst_n,
	pnu_cfg_if.sink cfg,
	pnu_pix_in_if.sink pix_in,
	pnu_pix_out_if.source pix_out
);

	localparam int NSTG = pnu_pkg::NSTG;
	localparam int TB   = pnu_pkg::TAB_BITS;

	typedef struct packed {
		logic [2:0][7:0] col;
		logic [7:0]      alpha;
	} pix_t;

	// config registers
	logic [13:0] amount_q;
	logic        gauss_q;
	logic        mono_q;
	logic [31:0] seed_q;
	logic [23:0] amtk_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amount_q <= '0;
			gauss_q <= 1'b0;
			mono_q <= 1'b0;
			seed_q <= '0;
			amtk_q <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (pnu_pkg::cfg_reg_t'(cfg.index))
					pnu_pkg::REG_AMOUNT: amount_q <= cfg.data[13:0];
					pnu_pkg::REG_GAUSS: gauss_q <= cfg.data[0];
					pnu_pkg::REG_MONO: mono_q <= cfg.data[0];
					pnu_pkg::REG_SEED: seed_q <= cfg.data;
					default: ;
				endcase
			end
			// scaled amount, registered from the amount register and the gaussian mode bit
			amtk_q <= amount_q * (gauss_q ? pnu_pkg::AMT_K_GAUSS : pnu_pkg::AMT_K_UNIF);
		end
	end

	// stage valid bits and per-stage load enables
	logic [NSTG:1]   vld_q;
	logic [NSTG+1:1] en;

	always_comb begin
		en[NSTG+1] = pix_out.ready;
		for (int k = NSTG; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign pix_in.ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) vld_q[1] <= pix_in.valid;
			for (int k = 2; k <= NSTG; k++) begin
				if (en[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	// pixel and unpremultiplied color travel alongside the noise path
	pix_t            pix_s [1:13];
	logic [2:0][15:0] v_s  [4:13];

	logic [2:0][7:0] col_in;
	assign col_in = {pix_in.blue_in, pix_in.green_in, pix_in.red_in};

	// stage 1: first hash round of the index, numerator and reciprocal for unpremultiply
	logic [31:0]      hm_s1;
	logic [24:0]      rcp_s1;
	logic [2:0][23:0] num_s1;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			hm_s1 <= pnu_pkg::xs16(pix_in.pixel_index) * pnu_pkg::MIX_C1;
			rcp_s1 <= pnu_pkg::RCP_TAB[pix_in.alpha_in];
			for (int c = 0; c < 3; c++) begin
				// c * 65280 + alpha / 2
				num_s1[c] <= ({col_in[c], 16'd0} - {8'd0, col_in[c], 8'd0})
					+ {16'd0, 1'b0, pix_in.alpha_in[7:1]};
			end
		end
	end

	// stage 2: second hash round, quotient estimate by reciprocal
	logic [31:0]      hm_s2;
	logic [2:0][23:0] num_s2;
	logic [2:0][24:0] q0_s2;
	logic [2:0][48:0] rprod;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			rprod[c] = 49'(num_s1[c]) * 49'(rcp_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			hm_s2 <= pnu_pkg::xs15(hm_s1) * pnu_pkg::MIX_C2;
			num_s2 <= num_s1;
			for (int c = 0; c < 3; c++) begin
				q0_s2[c] <= rprod[c][48:24];
			end
		end
	end

	// stage 3: seed mix into the second hash, back-multiply the estimate
	logic [31:0]      hm_s3;
	logic [2:0][23:0] num_s3;
	logic [2:0][24:0] q0_s3;
	logic [2:0][32:0] qa_s3;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			hm_s3 <= pnu_pkg::xs16(seed_q ^ pnu_pkg::xs16(hm_s2)) * pnu_pkg::MIX_C1;
			num_s3 <= num_s2;
			q0_s3 <= q0_s2;
			for (int c = 0; c < 3; c++) begin
				qa_s3[c] <= 33'(q0_s2[c]) * 33'(pix_s[2].alpha);
			end
		end
	end

	// stage 4: second round of the seeded hash, one correction step and saturation of the unpremultiplied value
	logic [31:0]      hm_s4;
	logic [2:0][32:0] urem;
	logic [2:0][24:0] uq;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			urem[c] = 33'(num_s3[c]) - qa_s3[c];
			uq[c] = q0_s3[c] + 25'(urem[c] >= 33'(pix_s[3].alpha));
		end
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			hm_s4 <= pnu_pkg::xs15(hm_s3) * pnu_pkg::MIX_C2;
		end
	end

	// stage 5: per-channel keys, first round of both draws
	logic [31:0]      base;
	logic [2:0][31:0] key;
	logic [2:0][31:0] ha_s5, hb_s5;

	always_comb begin
		base = pnu_pkg::xs16(hm_s4);
		for (int c = 0; c < 3; c++) begin
			key[c] = mono_q ? base : base + pnu_pkg::KEY_OFS[c];
		end
	end

	always_ff @(posedge clk) begin
		if (en[5]) begin
			for (int c = 0; c < 3; c++) begin
				ha_s5[c] <= pnu_pkg::xs16(key[c]) * pnu_pkg::MIX_C1;
				hb_s5[c] <= pnu_pkg::xs16(key[c] ^ pnu_pkg::KEY_SALT) * pnu_pkg::MIX_C1;
			end
		end
	end

	// stage 6: second round of both draws
	logic [2:0][31:0] ha_s6, hb_s6;

	always_ff @(posedge clk) begin
		if (en[6]) begin
			for (int c = 0; c < 3; c++) begin
				ha_s6[c] <= pnu_pkg::xs15(ha_s5[c]) * pnu_pkg::MIX_C2;
				hb_s6[c] <= pnu_pkg::xs15(hb_s5[c]) * pnu_pkg::MIX_C2;
			end
		end
	end

	// stage 7: 24-bit uniforms, radius and cosine lookups
	logic [2:0][31:0] fa, fb;
	logic [2:0][23:0] ua_s7;
	logic [2:0][15:0] rad_s7, cos_s7;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			fa[c] = pnu_pkg::xs16(ha_s6[c]);
			fb[c] = pnu_pkg::xs16(hb_s6[c]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[7]) begin
			for (int c = 0; c < 3; c++) begin
				ua_s7[c] <= fa[c][31:8];
				rad_s7[c] <= pnu_pkg::RAD_TAB[fa[c][31 -: TB]];
				cos_s7[c] <= pnu_pkg::COS_TAB[fb[c][31 -: TB]];
			end
		end
	end

	// stage 8: signed raw noise as magnitude and sign
	logic [2:0][25:0] mag_s8;
	logic [2:0]       neg_s8;
	logic [2:0][15:0] cmag;
	logic [2:0][31:0] gprod;
	logic [2:0][24:0] udbl;
	logic [2:0][24:0] umag;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			cmag[c] = cos_s7[c][15] ? 16'(-cos_s7[c]) : cos_s7[c];
			gprod[c] = 32'(rad_s7[c]) * 32'(cmag[c]);
			udbl[c] = {ua_s7[c], 1'b0};
			umag[c] = ua_s7[c][23] ? udbl[c] - 25'h1000000 : 25'h1000000 - udbl[c];
		end
	end

	always_ff @(posedge clk) begin
		if (en[8]) begin
			for (int c = 0; c < 3; c++) begin
				mag_s8[c] <= gauss_q ? gprod[c][25:0] : {1'b0, umag[c]};
				neg_s8[c] <= gauss_q ? cos_s7[c][15] : !ua_s7[c][23];
			end
		end
	end

	// stage 9: scale by amount
	logic [2:0][49:0] prod_s9;
	logic [2:0]       neg_s9;

	always_ff @(posedge clk) begin
		if (en[9]) begin
			neg_s9 <= neg_s8;
			for (int c = 0; c < 3; c++) begin
				prod_s9[c] <= 50'(mag_s8[c]) * 50'(amtk_q);
			end
		end
	end

	// stage 10: round-half bias and the power-of-two part of the divisor
	logic [2:0][29:0] x_s10;
	logic [2:0]       neg_s10;
	logic [2:0][49:0] xb;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			xb[c] = (prod_s9[c] + pnu_pkg::NZ_BIAS) >> pnu_pkg::NZ_SH;
		end
	end

	always_ff @(posedge clk) begin
		if (en[10]) begin
			neg_s10 <= neg_s9;
			for (int c = 0; c < 3; c++) begin
				x_s10[c] <= xb[c][29:0];
			end
		end
	end

	// stage 11: divide by 1875 through the reciprocal
	logic [2:0][29:0] x_s11;
	logic [2:0][19:0] q0n_s11;
	logic [2:0]       neg_s11;
	logic [2:0][58:0] xm;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			xm[c] = 59'(x_s10[c]) * 59'(pnu_pkg::NZ_RECIP);
		end
	end

	always_ff @(posedge clk) begin
		if (en[11]) begin
			neg_s11 <= neg_s10;
			x_s11 <= x_s10;
			for (int c = 0; c < 3; c++) begin
				q0n_s11[c] <= xm[c][pnu_pkg::NZ_RSH +: 20];
			end
		end
	end

	// stage 12: quotient correction
	logic [2:0][19:0] q_s12;
	logic [2:0]       neg_s12;
	logic [2:0][30:0] nrem;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			nrem[c] = 31'(x_s11[c]) - 31'(q0n_s11[c]) * 31'(pnu_pkg::NZ_DIV);
		end
	end

	always_ff @(posedge clk) begin
		if (en[12]) begin
			neg_s12 <= neg_s11;
			for (int c = 0; c < 3; c++) begin
				q_s12[c] <= q0n_s11[c] + 20'(nrem[c] >= 31'(pnu_pkg::NZ_DIV));
			end
		end
	end

	// stage 13: saturate noise, add, clamp, premultiply again
	logic signed [17:0]      nz [3];
	logic signed [18:0]      ssum [3];
	logic        [2:0][15:0] sc;
	logic        [2:0][23:0] sa_s13;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			if (neg_s12[c]) begin
				nz[c] = (q_s12[c] > 20'd65536) ? -18'sd65536 : -$signed({1'b0, q_s12[c][16:0]});
			end else begin
				nz[c] = (q_s12[c] > 20'd65535) ? 18'sd65535 : $signed({2'b0, q_s12[c][15:0]});
			end
			ssum[c] = $signed({3'b0, v_s[12][c]}) + 19'(nz[c]);
			if (ssum[c] < 0) sc[c] = '0;
			else if (ssum[c] > $signed({3'b0, pnu_pkg::S_MAX})) sc[c] = pnu_pkg::S_MAX;
			else sc[c] = ssum[c][15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en[13]) begin
			for (int c = 0; c < 3; c++) begin
				sa_s13[c] <= 24'(sc[c]) * 24'(pix_s[12].alpha);
			end
		end
	end

	// stage 14: round-to-nearest divide by 65280, alpha zero passes the pixel
	logic [2:0][7:0]  out_s14;
	logic [7:0]       alpha_s14;
	logic [2:0][23:0] xr;
	logic [2:0][15:0] yr;
	logic [2:0][24:0] y257;
	logic [2:0][8:0]  oq0;
	logic [2:0][16:0] orem;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			xr[c] = sa_s13[c] + 24'd32640;
			yr[c] = xr[c][23:8];
			y257[c] = {1'b0, yr[c], 8'd0} + 25'(yr[c]);
			oq0[c] = y257[c][24:16];
			orem[c] = 17'(yr[c]) - ({oq0[c], 8'd0} - 17'(oq0[c]));
		end
	end

	always_ff @(posedge clk) begin
		if (en[14]) begin
			alpha_s14 <= pix_s[13].alpha;
			for (int c = 0; c < 3; c++) begin
				out_s14[c] <= (pix_s[13].alpha == 8'd0) ? pix_s[13].col[c]
					: oq0[c][7:0] + 8'(orem[c] >= 17'd255);
			end
		end
	end

	// side-band carry of pixel and unpremultiplied color
	always_ff @(posedge clk) begin
		if (en[1]) begin
			pix_s[1].col <= col_in;
			pix_s[1].alpha <= pix_in.alpha_in;
		end
		for (int k = 2; k <= 13; k++) begin
			if (en[k]) pix_s[k] <= pix_s[k-1];
		end
		if (en[4]) begin
			for (int c = 0; c < 3; c++) begin
				v_s[4][c] <= (uq[c] > 25'(pnu_pkg::V_MAX)) ? pnu_pkg::V_MAX : uq[c][15:0];
			end
		end
		for (int k = 5; k <= 13; k++) begin
			if (en[k]) v_s[k] <= v_s[k-1];
		end
	end

	assign pix_out.valid = vld_q[NSTG];
	assign pix_out.red_out = out_s14[0];
	assign pix_out.green_out = out_s14[1];
	assign pix_out.blue_out = out_s14[2];
	assign pix_out.alpha_out = alpha_s14;

	// a repremultiplied channel never exceeds its alpha
	a_col_le_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		pix_out.valid && pix_out.alpha_out != 8'd0 |->
			pix_out.red_out <= pix_out.alpha_out && pix_out.green_out <= pix_out.alpha_out
			&& pix_out.blue_out <= pix_out.alpha_out)
		else $error("color above alpha");

	// a full pipeline facing a stalled output takes no transfer
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(&vld_q) && !pix_out.ready |-> !pix_in.ready)
		else $error("transfer taken into full pipeline");

	// mono mode gives all three channels the same draw
	a_mono_keys: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[5] && mono_q && $past(mono_q) && $past(en[5]) |->
			ha_s5[0] == ha_s5[1] && ha_s5[0] == ha_s5[2])
		else $error("mono draws differ");

endmodule

[test/tb_premultiplied_pixel_noise_unit.sv]
module tb_premultiplied_pixel_noise_unit;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 40;
	localparam int RAND_PER_PHASE = 60;
	localparam int NUM_PHASES = 9;

	typedef struct packed {
		logic [31:0] index;
		logic [7:0]  r;
		logic [7:0]  g;
		logic [7:0]  b;
		logic [7:0]  a;
	} pixel_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] a;
	} rgba_t;

	typedef struct packed {
		pnu_pkg::cfg_reg_t idx;
		logic [31:0]       data;
	} reg_write_t;

	logic clk;
	logic arst_n;

	pnu_cfg_if     cfg_bus ();
	pnu_pix_in_if  in_bus ();
	pnu_pix_out_if out_bus ();

	premultiplied_pixel_noise_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.pix_in (in_bus),
		.pix_out(out_bus)
	);

	// shadow copy of the noise settings, follows every register transfer
	logic [13:0] amount_q;
	logic        gauss_q;
	logic        mono_q;
	logic [31:0] seed_q;

	// box-muller lookups rebuilt here from integer arithmetic
	logic [15:0] radius_lut [pnu_pkg::TAB_SIZE];
	logic [15:0] cosine_lut [pnu_pkg::TAB_SIZE];

	pixel_t     pixel_q[$];
	reg_write_t reg_q[$];
	rgba_t      expected_q[$];

	int snd_idle_pct;
	int rcv_idle_pct;
	int fail_count;
	int cycle_count;

	function automatic logic [31:0] hash_mix(input logic [31:0] v);
		logic [31:0] x;
		x = v;
		x = x ^ (x >> 16);
		x = x * 32'h7feb352d;
		x = x ^ (x >> 15);
		x = x * 32'h846ca68b;
		x = x ^ (x >> 16);
		return x;
	endfunction

	// 2 * atanh(z) with z in Q32, which is ln((1 + z) / (1 - z))
	function automatic longint unsigned atanh_log(input longint unsigned z);
		longint unsigned z2, pw, acc;
		z2 = (z * z) >> 32;
		pw = z;
		acc = z;
		for (longint unsigned k = 1; k <= 15; k++) begin
			pw = (pw * z2) >> 32;
			acc += pw / (2 * k + 1);
		end
		return 2 * acc;
	endfunction

	function automatic longint unsigned root64(input longint unsigned v_in);
		longint unsigned v, res, bt;
		v = v_in;
		res = 0;
		bt = 64'd1 << 62;
		while (bt > v) bt >>= 2;
		while (bt != 0) begin
			if (v >= res + bt) begin
				v -= res + bt;
				res = (res >> 1) + bt;
			end else begin
				res >>= 1;
			end
			bt >>= 2;
		end
		return res;
	endfunction

	task automatic fill_luts();
		longint unsigned n, d, ln2, m, k, y, lny, l, one32;
		longint unsigned t, ang, ang2, term, one30;
		longint acc, c;
		logic neg;
		one32 = 64'd1 << 32;
		one30 = 64'd1 << 30;
		n = pnu_pkg::TAB_SIZE;
		d = 2 * n;
		ln2 = atanh_log(64'h55555555);
		for (int i = 0; i < pnu_pkg::TAB_SIZE; i++) begin
			// radius: sqrt(-2 ln(1 - (i + 0.5) / n)), log taken as exponent plus mantissa
			m = d - (2 * longint'(i) + 1);
			k = 0;
			while ((m >> (k + 1)) != 0) k++;
			y = (m << 32) >> k;
			lny = atanh_log(((y - one32) << 32) / (y + one32));
			l = (longint'(pnu_pkg::TAB_BITS + 1) - k) * ln2;
			l = (l > lny) ? l - lny : 0;
			l *= 2;
			radius_lut[i] = 16'((root64(l) + 8) >> 4);
			// cosine: fold into the first quadrant, taylor series there
			t = 2 * longint'(i) + 1;
			neg = 1'b0;
			if (t > n) t = d - t;
			if (2 * t > n) begin
				neg = 1'b1;
				t = n - t;
			end
			ang = (64'd3373259426 * t) / n;
			ang2 = (ang * ang) >> 30;
			term = one30;
			acc = longint'(one30);
			for (longint unsigned j = 1; j <= 12; j++) begin
				term = ((term * ang2) >> 30) / ((2 * j - 1) * (2 * j));
				if (j[0]) acc -= longint'(term);
				else acc += longint'(term);
			end
			if (acc < 0) acc = 0;
			c = longint'((unsigned'(acc) + (64'd1 << 17)) >> 18);
			cosine_lut[i] = neg ? 16'(-c) : 16'(c);
		end
	endtask

	// divide rounding half away from zero
	function automatic longint round_div(input longint num, input longint den);
		longint mag, q;
		mag = (num < 0) ? -num : num;
		q = (mag + den / 2) / den;
		return (num < 0) ? -q : q;
	endfunction

	function automatic longint channel_noise(input logic [31:0] key);
		logic [23:0] u1, u2;
		longint rad, cs, nz, amt;
		amt = longint'(amount_q);
		u1 = 24'(hash_mix(key) >> 8);
		if (gauss_q) begin
			u2 = 24'(hash_mix(key ^ 32'h68e31da4) >> 8);
			rad = longint'(radius_lut[u1[23:24-pnu_pkg::TAB_BITS]]);
			cs = longint'(signed'(cosine_lut[u2[23:24-pnu_pkg::TAB_BITS]]));
			nz = round_div(rad * cs * amt * 510, longint'(60000) * 65536);
		end else begin
			nz = round_div((2 * longint'(u1) - 16777216) * amt * 255,
				longint'(20000) * 65536);
		end
		if (nz < -65536) nz = -65536;
		if (nz > 65535) nz = 65535;
		return nz;
	endfunction

	function automatic rgba_t noisy_pixel(input pixel_t p);
		rgba_t res;
		logic [7:0] col [3];
		logic [31:0] base, key;
		longint v, s, alpha;
		col[0] = p.r;
		col[1] = p.g;
		col[2] = p.b;
		alpha = longint'(p.a);
		// zero alpha leaves the pixel untouched
		if (p.a != 0) begin
			base = hash_mix(seed_q ^ hash_mix(p.index));
			for (int c = 0; c < 3; c++) begin
				key = mono_q ? base : base + 32'(c) * 32'h9e3779b9;
				// color above alpha saturates here
				v = (longint'(col[c]) * 65280 + alpha / 2) / alpha;
				if (v > 65535) v = 65535;
				s = v + channel_noise(key);
				if (s < 0) s = 0;
				if (s > 65280) s = 65280;
				col[c] = 8'((s * alpha + 32640) / 65280);
			end
		end
		res.r = col[0];
		res.g = col[1];
		res.b = col[2];
		res.a = p.a;
		return res;
	endfunction

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = '0;
		cfg_bus.data = '0;
		in_bus.valid = 1'b0;
		in_bus.pixel_index = '0;
		in_bus.red_in = '0;
		in_bus.green_in = '0;
		in_bus.blue_in = '0;
		in_bus.alpha_in = '0;
		out_bus.ready = 1'b0;
		forever #6 clk = ~clk;
	end

	// register write driver, also keeps the shadow settings
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_bus.valid <= 1'b0;
			amount_q <= '0;
			gauss_q <= 1'b0;
			mono_q <= 1'b0;
			seed_q <= '0;
		end else begin
			if (cfg_bus.valid && cfg_bus.ready) begin
				case (cfg_bus.index)
					pnu_pkg::REG_AMOUNT: amount_q <= cfg_bus.data[13:0];
					pnu_pkg::REG_GAUSS:  gauss_q <= cfg_bus.data[0];
					pnu_pkg::REG_MONO:   mono_q <= cfg_bus.data[0];
					pnu_pkg::REG_SEED:   seed_q <= cfg_bus.data;
					default: ;
				endcase
			end
			if (!cfg_bus.valid || cfg_bus.ready) begin
				if (reg_q.size() > 0) begin
					cfg_bus.valid <= 1'b1;
					cfg_bus.index <= reg_q[0].idx;
					cfg_bus.data <= reg_q[0].data;
					void'(reg_q.pop_front());
				end else begin
					cfg_bus.valid <= 1'b0;
				end
			end
		end
	end

	// pixel driver, predicts each pixel on its input transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_bus.valid <= 1'b0;
		end else begin
			if (in_bus.valid && in_bus.ready) begin
				expected_q.push_back(noisy_pixel({in_bus.pixel_index, in_bus.red_in,
					in_bus.green_in, in_bus.blue_in, in_bus.alpha_in}));
			end
			if (!in_bus.valid || in_bus.ready) begin
				if (pixel_q.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
					in_bus.valid <= 1'b1;
					in_bus.pixel_index <= pixel_q[0].index;
					in_bus.red_in <= pixel_q[0].r;
					in_bus.green_in <= pixel_q[0].g;
					in_bus.blue_in <= pixel_q[0].b;
					in_bus.alpha_in <= pixel_q[0].a;
					void'(pixel_q.pop_front());
				end else begin
					in_bus.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor with random back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_bus.ready <= 1'b0;
		end else begin
			out_bus.ready <= ($urandom_range(99) >= rcv_idle_pct);
			if (out_bus.valid && out_bus.ready) begin
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result r=%0d g=%0d b=%0d a=%0d", $time,
						out_bus.red_out, out_bus.green_out, out_bus.blue_out,
						out_bus.alpha_out);
					fail_count++;
				end else begin
					if (out_bus.red_out !== expected_q[0].r) begin
						$display("%0t: red expected %0d actual %0d", $time,
							expected_q[0].r, out_bus.red_out);
						fail_count++;
					end
					if (out_bus.green_out !== expected_q[0].g) begin
						$display("%0t: green expected %0d actual %0d", $time,
							expected_q[0].g, out_bus.green_out);
						fail_count++;
					end
					if (out_bus.blue_out !== expected_q[0].b) begin
						$display("%0t: blue expected %0d actual %0d", $time,
							expected_q[0].b, out_bus.blue_out);
						fail_count++;
					end
					if (out_bus.alpha_out !== expected_q[0].a) begin
						$display("%0t: alpha expected %0d actual %0d", $time,
							expected_q[0].a, out_bus.alpha_out);
						fail_count++;
					end
					void'(expected_q.pop_front());
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic pixel_t mk_pixel(input logic [31:0] idx, input logic [7:0] r,
		input logic [7:0] g, input logic [7:0] b, input logic [7:0] a);
		pixel_t p;
		p.index = idx;
		p.r = r;
		p.g = g;
		p.b = b;
		p.a = a;
		return p;
	endfunction

	// mostly well-formed premultiplied pixels, some with color above alpha
	function automatic pixel_t random_pixel(input logic [31:0] idx);
		pixel_t p;
		int sel;
		sel = $urandom_range(99);
		p.index = idx;
		if (sel < 5) p.a = 8'd0;
		else if (sel < 15) p.a = 8'd255;
		else p.a = 8'($urandom_range(255));
		if ($urandom_range(9) == 0) begin
			p.r = 8'($urandom);
			p.g = 8'($urandom);
			p.b = 8'($urandom);
		end else begin
			p.r = 8'($urandom_range(p.a));
			p.g = 8'($urandom_range(p.a));
			p.b = 8'($urandom_range(p.a));
		end
		return p;
	endfunction

	initial begin
		logic [31:0] idx;
		logic [31:0] amt;
		cycle_count = 0;
		fail_count = 0;
		snd_idle_pct = 10;
		rcv_idle_pct = 76;
		fill_luts();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			// idle pattern: sender light / receiver heavy, then swapped, then none
			if (ph < 3) begin
				snd_idle_pct = 10;
				rcv_idle_pct = 76;
			end else if (ph < 6) begin
				snd_idle_pct = 76;
				rcv_idle_pct = 10;
			end else begin
				snd_idle_pct = 0;
				rcv_idle_pct = 0;
			end

			if (ph == 2) amt = 0;
			else if (ph % 3 == 0) amt = 10000;
			else if (ph % 3 == 1) amt = 16383;
			else amt = $urandom_range(16383);
			reg_q.push_back({pnu_pkg::REG_AMOUNT, amt});
			reg_q.push_back({pnu_pkg::REG_GAUSS, 32'(ph % 2)});
			reg_q.push_back({pnu_pkg::REG_MONO, 32'((ph / 2) % 2)});
			if (ph == 0) reg_q.push_back({pnu_pkg::REG_SEED, 32'h0});
			else if (ph == 1) reg_q.push_back({pnu_pkg::REG_SEED, 32'hffffffff});
			else reg_q.push_back({pnu_pkg::REG_SEED, $urandom});
			while (reg_q.size() > 0 || cfg_bus.valid) @(posedge clk);

			if (ph == 0) begin
				// directed corners: zero alpha, full alpha, color above alpha
				pixel_q.push_back(mk_pixel(32'h0, 8'd0, 8'd0, 8'd0, 8'd0));
				pixel_q.push_back(mk_pixel(32'hffffffff, 8'd255, 8'd255, 8'd255, 8'd0));
				pixel_q.push_back(mk_pixel(32'h12345678, 8'd17, 8'd200, 8'd99, 8'd0));
				pixel_q.push_back(mk_pixel(32'h0, 8'd0, 8'd0, 8'd0, 8'd255));
				pixel_q.push_back(mk_pixel(32'hffffffff, 8'd255, 8'd255, 8'd255, 8'd255));
				pixel_q.push_back(mk_pixel(32'h1, 8'd128, 8'd64, 8'd32, 8'd255));
				pixel_q.push_back(mk_pixel(32'h2, 8'd255, 8'd0, 8'd255, 8'd1));
				pixel_q.push_back(mk_pixel(32'h3, 8'd1, 8'd1, 8'd0, 8'd1));
				pixel_q.push_back(mk_pixel(32'h80000000, 8'd200, 8'd100, 8'd50, 8'd100));
				pixel_q.push_back(mk_pixel(32'h7fffffff, 8'd128, 8'd128, 8'd128, 8'd128));
				pixel_q.push_back(mk_pixel(32'haaaaaaaa, 8'd85, 8'd170, 8'd0, 8'd170));
				pixel_q.push_back(mk_pixel(32'h55555555, 8'd127, 8'd0, 8'd127, 8'd127));
			end
			idx = $urandom;
			for (int n = 0; n < RAND_PER_PHASE; n++) begin
				// raster runs of consecutive indices with occasional jumps
				if ($urandom_range(7) == 0) idx = $urandom;
				else idx = idx + 1;
				pixel_q.push_back(random_pixel(idx));
			end
			while (pixel_q.size() > 0 || in_bus.valid || expected_q.size() > 0)
				@(posedge clk);
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && expected_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
